[rtl/core/pbw_pkg.sv]
package pbw_pkg;

    localparam int COORD_W   = 32;
    localparam int MARGIN_W  = 31;
    localparam int REQ_W     = 2;
    localparam int NUM_AXES  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W    = 1;
    localparam int DIV_STEPS = COORD_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_TEST = 2'd0,
        REQ_WRAP = 2'd1,
        REQ_MIMG = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_X = 3'd0,
        CFG_A_Y = 3'd1,
        CFG_A_Z = 3'd2,
        CFG_B_X = 3'd3,
        CFG_B_Y = 3'd4,
        CFG_B_Z = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] lo;
        logic [COORD_W-1:0]        ext;
    } axis_cfg_t;

    typedef struct packed {
        logic                      wrap;
        logic                      neg;
        logic [COORD_W-1:0]        mag;
        logic [COORD_W-1:0]        ext;
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] pass;
    } axis_job_t;

    typedef struct packed {
        axis_job_t [NUM_AXES-1:0] ax;
        logic                     contained;
    } job_t;

endpackage

[rtl/core/pbw_if.sv]
interface pbw_in_if;
    import pbw_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [REQ_W-1:0]           req_type;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
    logic [MARGIN_W-1:0]        margin;

    modport source (output valid, req_type, coord_x, coord_y, coord_z, margin, input ready);
    modport sink (input valid, req_type, coord_x, coord_y, coord_z, margin, output ready);
endinterface

interface pbw_out_if;
    import pbw_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  out_x;
    logic signed [COORD_W-1:0]  out_y;
    logic signed [COORD_W-1:0]  out_z;
    logic                       inside_res;

    modport source (output valid, out_x, out_y, out_z, inside_res, input ready);
    modport sink (input valid, out_x, out_y, out_z, inside_res, output ready);
endinterface

[rtl/core/pbw_front.sv]
module pbw_front
    import pbw_pkg::*;
(
    input  axis_cfg_t [NUM_AXES-1:0]   cfg,
    input  logic [REQ_W-1:0]           req_type,
    input  logic [NUM_AXES-1:0][COORD_W-1:0] coord,
    input  logic [MARGIN_W-1:0]        margin,
    output job_t                       job
);

    req_t req;
    logic [NUM_AXES-1:0] ok;

    assign req = req_t'(req_type);

    always_comb
    begin
        logic signed [COORD_W+1:0] v;
        logic signed [COORD_W+1:0] lo;
        logic signed [COORD_W+1:0] hi;
        logic signed [COORD_W+1:0] m;
        logic signed [COORD_W+1:0] d;
        logic signed [COORD_W+2:0] x;
        logic signed [COORD_W+2:0] e;
        logic                      act;
        job = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            v  = {{2{coord[i][COORD_W-1]}}, coord[i]};
            lo = {{2{cfg[i].lo[COORD_W-1]}}, cfg[i].lo};
            hi = lo + {2'b00, cfg[i].ext};
            m  = {3'b000, margin};
            act = (cfg[i].ext != '0);
            ok[i] = !act || ((v >= lo - m) && (v <= hi + m));

            // wrap: split v - lo into sign and magnitude for the divider
            d = v - lo;
            job.ax[i].neg  = d[COORD_W+1];
            job.ax[i].mag  = d[COORD_W+1] ? COORD_W'(-d) : d[COORD_W-1:0];
            job.ax[i].ext  = cfg[i].ext;
            job.ax[i].lo   = cfg[i].lo;
            job.ax[i].wrap = act && (req == REQ_WRAP);

            // minimum image: 2x >= E subtracts E, then 2x < -E adds E
            x = {{3{coord[i][COORD_W-1]}}, coord[i]};
            e = {3'b000, cfg[i].ext};
            if ((x <<< 1) >= e)
                x = x - e;
            if ((x <<< 1) < -e)
                x = x + e;
            if (act && req == REQ_MIMG)
                job.ax[i].pass = x[COORD_W-1:0];
            else
                job.ax[i].pass = coord[i];
        end
        job.contained = (req == REQ_TEST) && (&ok);
    end

endmodule

[rtl/core/pbw_queue.sv]
module pbw_queue
    import pbw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output job_t rd_data
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;
    logic              pop;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_en && !full;
    assign pop      = rd_en && rd_valid;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/pbw_back.sv]
module pbw_back
    import pbw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  job_t q_data,
    output logic q_pop,
    pbw_out_if.source rsp
);

    typedef struct packed {
        job_t                                  job;
        logic [NUM_AXES-1:0][COORD_W-1:0]      rem;
    } stage_t;

    stage_t stage_reg [DIV_STEPS+1];
    logic   valid_reg [DIV_STEPS+1];
    logic   en;
    logic   out_valid_reg;
    logic [NUM_AXES-1:0][COORD_W-1:0] res_reg;
    logic   inside_reg;
    logic [NUM_AXES-1:0][COORD_W-1:0] res_next;

    assign en    = !out_valid_reg || rsp.ready;
    assign q_pop = en;

    function automatic stage_t div_step(input stage_t s);
        stage_t           o;
        logic [COORD_W:0] t;
        o = s;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            t = {s.rem[i], s.job.ax[i].mag[COORD_W-1]};
            if (t >= {1'b0, s.job.ax[i].ext})
                t = t - {1'b0, s.job.ax[i].ext};
            o.rem[i] = t[COORD_W-1:0];
            o.job.ax[i].mag = {s.job.ax[i].mag[COORD_W-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb
    begin
        logic [COORD_W-1:0] m;
        logic [COORD_W-1:0] r;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            m = stage_reg[DIV_STEPS].rem[i];
            r = (stage_reg[DIV_STEPS].job.ax[i].neg && m != '0)
                ? stage_reg[DIV_STEPS].job.ax[i].ext - m : m;
            if (stage_reg[DIV_STEPS].job.ax[i].wrap)
                res_next[i] = stage_reg[DIV_STEPS].job.ax[i].lo + r;
            else
                res_next[i] = stage_reg[DIV_STEPS].job.ax[i].pass;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0].job <= q_data;
            stage_reg[0].rem <= '0;
            for (int s = 0; s < DIV_STEPS; s++)
                stage_reg[s+1] <= div_step(stage_reg[s]);
            res_reg    <= res_next;
            inside_reg <= stage_reg[DIV_STEPS].job.contained;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STEPS; s++)
                valid_reg[s] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= q_valid;
            for (int s = 0; s < DIV_STEPS; s++)
                valid_reg[s+1] <= valid_reg[s];
            out_valid_reg <= valid_reg[DIV_STEPS];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.out_x      = res_reg[0];
    assign rsp.out_y      = res_reg[1];
    assign rsp.out_z      = res_reg[2];
    assign rsp.inside_res = inside_reg;

endmodule

[rtl/core/periodic_box_wrap_unit.sv]
// Periodic box unit: containment test, wrap and minimum-image correction.
// Channels: req (sink) carries req_type, coord_x/y/z and margin; rsp
// (source) carries out_x/y/z and inside_res, one beat per request beat,
// in order. Both use valid/ready; a beat moves when both are high.
// Config: cfg_we/cfg_idx/cfg_data write the six corner registers; write
// only while no request is in flight.
// Throughput: one beat per cycle while rsp.ready is high. A request beat
// passes a queue slot, an input stage register, 32 restoring-divider
// steps for the wrap remainder and a result register. Every operation
// runs through the same divider pipeline so order is kept.
// Reset: corners clear to zero (inactive box), queue and pipeline empty.
// Stall: with rsp.valid high and rsp.ready low the pipeline holds; the
// two-entry queue takes request beats until full, then req.ready drops.
module periodic_box_wrap_unit
    import pbw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [COORD_W-1:0]   cfg_data,
    pbw_in_if.sink               req,
    pbw_out_if.source            rsp
);

    logic [NUM_AXES-1:0][COORD_W-1:0] corner_a_reg;
    logic [NUM_AXES-1:0][COORD_W-1:0] corner_b_reg;
    axis_cfg_t [NUM_AXES-1:0]         cfg;
    logic [NUM_AXES-1:0][COORD_W-1:0] coord;
    job_t job;
    job_t q_data;
    logic q_full;
    logic q_valid;
    logic q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_a_reg <= '0;
            corner_b_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_idx))
                CFG_A_X: corner_a_reg[0] <= cfg_data;
                CFG_A_Y: corner_a_reg[1] <= cfg_data;
                CFG_A_Z: corner_a_reg[2] <= cfg_data;
                CFG_B_X: corner_b_reg[0] <= cfg_data;
                CFG_B_Y: corner_b_reg[1] <= cfg_data;
                CFG_B_Z: corner_b_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if ($signed(corner_a_reg[i]) < $signed(corner_b_reg[i]))
            begin
                cfg[i].lo  = corner_a_reg[i];
                cfg[i].ext = corner_b_reg[i] - corner_a_reg[i];
            end
            else
            begin
                cfg[i].lo  = corner_b_reg[i];
                cfg[i].ext = corner_a_reg[i] - corner_b_reg[i];
            end
        end
    end

    assign coord[0]  = req.coord_x;
    assign coord[1]  = req.coord_y;
    assign coord[2]  = req.coord_z;
    assign req.ready = !q_full;

    pbw_front u_front (
        .cfg      (cfg),
        .req_type (req.req_type),
        .coord    (coord),
        .margin   (req.margin),
        .job      (job)
    );

    pbw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (req.valid),
        .wr_data  (job),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    pbw_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

[tb/sv/pbw_box_checker.sv]
module pbw_box_checker
    import pbw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [COORD_W-1:0]   cfg_data,
    input  logic                 req_valid,
    input  logic                 req_ready,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [COORD_W-1:0]   coord_x,
    input  logic [COORD_W-1:0]   coord_y,
    input  logic [COORD_W-1:0]   coord_z,
    input  logic [MARGIN_W-1:0]  margin,
    input  logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  logic [COORD_W-1:0]   out_x,
    input  logic [COORD_W-1:0]   out_y,
    input  logic [COORD_W-1:0]   out_z,
    input  logic                 inside_res,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               contained;
    } box_result_t;

    logic signed [COORD_W-1:0] corner_a [NUM_AXES];
    logic signed [COORD_W-1:0] corner_b [NUM_AXES];
    box_result_t expected_q [$];

    function automatic box_result_t box_predict(logic [REQ_W-1:0] rt,
        logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cz,
        logic [MARGIN_W-1:0] mg);
        logic signed [63:0] v, lo, hi, ext, r, rem, m;
        logic [COORD_W-1:0] c [NUM_AXES];
        logic [COORD_W-1:0] o [NUM_AXES];
        logic in_box;
        box_result_t res;
        c[0] = cx; c[1] = cy; c[2] = cz;
        m = {33'd0, mg};
        in_box = 1'b1;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            v = 64'(signed'(c[i]));
            lo = (corner_a[i] < corner_b[i]) ? 64'(corner_a[i]) : 64'(corner_b[i]);
            hi = (corner_a[i] < corner_b[i]) ? 64'(corner_b[i]) : 64'(corner_a[i]);
            ext = hi - lo;
            r = v;
            if (ext != 0)
            begin
                if (rt == REQ_TEST)
                begin
                    if (v < lo - m || v > hi + m)
                        in_box = 1'b0;
                end
                else if (rt == REQ_WRAP)
                begin
                    rem = (v - lo) % ext;
                    if (rem < 0)
                        rem += ext;
                    r = lo + rem;
                end
                else if (rt == REQ_MIMG)
                begin
                    if (2 * r >= ext)
                        r -= ext;
                    if (2 * r < -ext)
                        r += ext;
                end
            end
            o[i] = r[COORD_W-1:0];
        end
        res.x = o[0]; res.y = o[1]; res.z = o[2];
        res.contained = (rt == REQ_TEST) && in_box;
        return res;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        box_result_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                corner_a[i] <= '0;
                corner_b[i] <= '0;
            end
            fail_count <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx < NUM_AXES)
                    corner_a[cfg_idx] <= cfg_data;
                else if (cfg_idx < 2 * NUM_AXES)
                    corner_b[cfg_idx - NUM_AXES] <= cfg_data;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected beat x=%h y=%h z=%h in=%b",
                                 out_x, out_y, out_z, inside_res);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (exp_r != {out_x, out_y, out_z, inside_res})
                    begin
                        if (fail_count < 10)
                            $display("mismatch exp x=%h y=%h z=%h in=%b got x=%h y=%h z=%h in=%b",
                                     exp_r.x, exp_r.y, exp_r.z, exp_r.contained,
                                     out_x, out_y, out_z, inside_res);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req_valid && req_ready)
                expected_q.push_back(box_predict(req_type, coord_x, coord_y, coord_z, margin));
        end
    end

endmodule

[tb/sv/periodic_box_wrap_unit_tb.sv]
module periodic_box_wrap_unit_tb;
    import pbw_pkg::*;

    localparam int LATENCY = 40;
    localparam int CYCLE_LIMIT = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [COORD_W-1:0]   cfg_data;
    int                   fail_count;
    int                   pending;
    int                   cycles;
    bit                   calm;

    pbw_in_if  req_ch();
    pbw_out_if rsp_ch();

    periodic_box_wrap_unit u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .req(req_ch.sink), .rsp(rsp_ch.source)
    );

    pbw_box_checker u_check (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data),
        .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_type(req_ch.req_type),
        .coord_x(req_ch.coord_x), .coord_y(req_ch.coord_y), .coord_z(req_ch.coord_z),
        .margin(req_ch.margin),
        .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .out_x(rsp_ch.out_x),
        .out_y(rsp_ch.out_y), .out_z(rsp_ch.out_z), .inside_res(rsp_ch.inside_res),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stalls at random, except during the calm stretch
    always @(posedge clk)
        rsp_ch.ready <= calm || ($urandom_range(99) >= 19);

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(signed'($urandom_range(2000)) - 1000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] rand_corner();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(signed'($urandom_range(200)) - 100);
            default: return $urandom();
        endcase
    endfunction

    // write enable stays high across back-to-back writes; caller drops it
    task automatic write_reg(cfg_idx_t idx, logic [COORD_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic send_item(logic [REQ_W-1:0] rt, logic [COORD_W-1:0] x,
        logic [COORD_W-1:0] y, logic [COORD_W-1:0] z, logic [MARGIN_W-1:0] mg);
        while (!calm && $urandom_range(99) < 19)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.coord_x <= x;
        req_ch.coord_y <= y;
        req_ch.coord_z <= z;
        req_ch.margin <= mg;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_random(int n);
        logic [MARGIN_W-1:0] mg;
        for (int k = 0; k < n; k++)
        begin
            mg = ($urandom_range(3) == 0) ? MARGIN_W'($urandom()) :
                 MARGIN_W'($urandom_range(300));
            send_item(REQ_W'($urandom_range(3)), rand_coord(), rand_coord(),
                      rand_coord(), mg);
        end
        req_ch.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        cycles = 0;
        calm = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.coord_x = '0;
        req_ch.coord_y = '0;
        req_ch.coord_z = '0;
        req_ch.margin = '0;
        rsp_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // inactive box after reset
        send_item(REQ_TEST, 32'h8000_0000, 32'h7fff_ffff, 32'd5, '0);
        send_item(REQ_WRAP, 32'h1234, 32'h8000_0000, 32'h7fff_ffff, '1);
        req_ch.valid <= 1'b0;
        drain();

        // extreme box: full range on x, small box on y, flat z
        write_reg(CFG_A_X, 32'h7fff_ffff);
        write_reg(CFG_B_X, 32'h8000_0000);
        write_reg(CFG_A_Y, 32'd10);
        write_reg(CFG_B_Y, 32'hffff_fff6);
        write_reg(CFG_A_Z, 32'd7);
        write_reg(CFG_B_Z, 32'd7);
        cfg_we <= 1'b0;
        for (int r = 0; r < 4; r++)
        begin
            send_item(REQ_W'(r), 32'h8000_0000, 32'd10, 32'd7, '0);
            send_item(REQ_W'(r), 32'h7fff_ffff, 32'hffff_fff6, 32'h8000_0000, '1);
            send_item(REQ_W'(r), 32'h3fff_ffff, 32'd11, 32'd0, 31'd1);
            send_item(REQ_W'(r), 32'hc000_0000, 32'hffff_fff5, 32'd1, 31'd2);
            send_item(REQ_W'(r), 32'd0, 32'h8000_0000, 32'h7fff_ffff, 31'd0);
        end
        req_ch.valid <= 1'b0;
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            for (int i = 0; i < 6; i++)
                write_reg(cfg_idx_t'(i), (ph == 9) ? 32'd0 : rand_corner());
            cfg_we <= 1'b0;
            calm = (ph == 4);
            send_random(110);
            drain();
        end
        calm = 1'b0;

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
